### design/ppg_slope_smoothing_filter_assert.svh
//------------------------------------------------------------------------------
// ppg_slope_smoothing_filter_assert.svh
// Assertion macros shared by the slope smoothing filter modules.
//------------------------------------------------------------------------------
`ifndef PPG_SLOPE_SMOOTHING_FILTER_ASSERT_SVH
`define PPG_SLOPE_SMOOTHING_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PSSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PSSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pssf_pkg.sv
//------------------------------------------------------------------------------
// pssf_pkg
// Types, register codes and constants of the slope smoothing filter.
//------------------------------------------------------------------------------
package pssf_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int RAW_W       = 16;
  localparam int LEVEL_OUT_W = 24;
  localparam int GAIN_W      = 8;
  localparam int GAIN_SHIFT  = 8;
  localparam int LIMIT_W     = 15;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  SLOPE_GAIN_RST   = 8'd46;
  localparam logic [GAIN_W-1:0]  DECAY_GAIN_RST   = 8'd205;
  localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 15'd500;

  typedef enum logic [1:0] {
    REG_SLOPE_GAIN   = 2'd0,
    REG_DECAY_GAIN   = 2'd1,
    REG_OUTPUT_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  slope_gain;
    logic [GAIN_W-1:0]  decay_gain;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic sample_fire;
    logic level_fire;
  } lane_ctl_t;

  typedef struct packed {
    logic             sample_valid;
    logic [RAW_W-1:0] raw_infrared;
    logic [RAW_W-1:0] raw_red;
  } tick_t;

  typedef struct packed {
    logic signed [LEVEL_OUT_W-1:0] infrared_level;
    logic signed [LEVEL_OUT_W-1:0] red_level;
  } result_t;

endpackage

### design/ppg_slope_smoothing_filter.sv
//------------------------------------------------------------------------------
// ppg_slope_smoothing_filter
// Two-channel slope smoothing and leaky level filter for infrared/red samples.
//------------------------------------------------------------------------------
// Each accepted tick transfer yields exactly one result transfer carrying both
// levels. The infrared and red channels run as two identical lanes side by
// side, and an output register merges their levels into one result. A tick
// enters on acceptance, where each lane updates its slope and last sample;
// once the output register is free, the lanes fold that slope into their
// level (add, multiply by the decay gain, clamp) and the result is registered.
// A new tick is taken every cycle while results drain, unless result_stall
// holds the output register full. The level feedback loop, one add, one
// 8-bit gain multiply and one clamp, and the single output register set
// that rate: when result_stall holds the output register full, the pending
// level update waits and tick_stall rises. Gains are unsigned 0.8 fractions;
// products are truncated toward zero so a level with zero slope leaks to zero.
// Registers sit at byte addresses 0 (slope_gain), 4 (decay_gain) and 8
// (output_limit, whole units); write them only while the filter is idle.
//------------------------------------------------------------------------------
module ppg_slope_smoothing_filter import pssf_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick_valid,
  output logic                  tick_stall,
  input  tick_t                 tick_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LEVEL_W = LIMIT_W + FRAC_BITS + 1;

  cfg_t                      cfg;
  logic                      pending;
  logic                      tick_fire;
  logic                      level_fire;
  logic                      out_free;
  logic                      cfg_write;
  reg_idx_t                  reg_idx;
  lane_ctl_t                 infrared_ctl;
  lane_ctl_t                 red_ctl;
  logic signed [LEVEL_W-1:0] infrared_level_next;
  logic signed [LEVEL_W-1:0] red_level_next;

  // Register file: write in the access phase, read back combinationally.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope_gain   <= SLOPE_GAIN_RST;
      cfg.decay_gain   <= DECAY_GAIN_RST;
      cfg.output_limit <= OUTPUT_LIMIT_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SLOPE_GAIN:   cfg.slope_gain   <= pwdata[GAIN_W-1:0];
        REG_DECAY_GAIN:   cfg.decay_gain   <= pwdata[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: cfg.output_limit <= pwdata[LIMIT_W-1:0];
        default: begin
          // drop writes to unmapped addresses
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLOPE_GAIN:   prdata = APB_DATA_W'(cfg.slope_gain);
      REG_DECAY_GAIN:   prdata = APB_DATA_W'(cfg.decay_gain);
      REG_OUTPUT_LIMIT: prdata = APB_DATA_W'(cfg.output_limit);
      default:          prdata = '0;
    endcase
  end

  // Two-step flow: pending marks a tick whose slope is in, level not yet.
  // Hold new ticks only while that level update cannot reach the output.
  assign level_fire = pending && out_free;
  assign tick_stall = pending && !out_free;
  assign tick_fire  = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= tick_fire || (pending && !level_fire);
    end
  end

  assign infrared_ctl.sample_fire = tick_fire && tick_data.sample_valid;
  assign infrared_ctl.level_fire  = level_fire;
  assign red_ctl.sample_fire      = tick_fire && tick_data.sample_valid;
  assign red_ctl.level_fire       = level_fire;

  pssf_lane #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_infrared (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctl        (infrared_ctl),
    .raw        (tick_data.raw_infrared),
    .level_next (infrared_level_next)
  );

  pssf_lane #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_red (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctl        (red_ctl),
    .raw        (tick_data.raw_red),
    .level_next (red_level_next)
  );

  // Merge both lane levels into the registered result transfer.
  pssf_merge #(
    .LEVEL_W (LEVEL_W)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .level_fire     (level_fire),
    .infrared_level (infrared_level_next),
    .red_level      (red_level_next),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .result_data    (result_data),
    .out_free       (out_free)
  );

`include "ppg_slope_smoothing_filter_assert.svh"

`PSSF_ASSERT_NEXT(a_tick_sets_pending, tick_valid && !tick_stall, pending, "accepted tick left no pending level update")
`PSSF_ASSERT_NEXT(a_level_makes_result, level_fire, result_valid, "level update produced no result")

endmodule

### design/pssf_lane.sv
//------------------------------------------------------------------------------
// pssf_lane
// One channel: slope estimate from sample differences, leaky clamped level.
//------------------------------------------------------------------------------
module pssf_lane import pssf_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEVEL_W    = LIMIT_W + FRAC_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  lane_ctl_t                 ctl,
  input  logic [RAW_W-1:0]          raw,
  output logic signed [LEVEL_W-1:0] level_next
);

  localparam int SLOPE_W   = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int RAW_EXT_W = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam int ERR_W     = SLOPE_W + 1;
  localparam int SSUM_W    = SLOPE_W + 2;
  localparam int LSUM_W    = ((LEVEL_W > SLOPE_W) ? LEVEL_W : SLOPE_W) + 1;
  localparam int BOUND_W   = LIMIT_W + FRAC_BITS;
  localparam logic signed [SSUM_W-1:0] SLOPE_MAX =
    SSUM_W'((longint'(1) << (SAMPLE_BITS + FRAC_BITS)) - longint'(1));

  logic [SAMPLE_BITS-1:0]           last;
  logic signed [SLOPE_W-1:0]        slope;
  logic signed [LEVEL_W-1:0]        level;

  logic [RAW_EXT_W-1:0]             raw_ext;
  logic [SAMPLE_BITS-1:0]           raw_s;
  logic signed [SAMPLE_BITS:0]      delta;
  logic signed [SLOPE_W-1:0]        diff;
  logic signed [ERR_W-1:0]          err;
  logic [ERR_W-1:0]                 err_mag;
  logic [ERR_W+GAIN_W-1:0]          err_prod;
  logic [ERR_W-1:0]                 err_q;
  logic signed [SSUM_W-1:0]         err_scaled;
  logic signed [SSUM_W-1:0]         slope_sum;
  logic signed [SSUM_W-1:0]         slope_clamped;
  logic signed [SLOPE_W-1:0]        slope_next;

  logic signed [LSUM_W-1:0]         lsum;
  logic [LSUM_W-1:0]                lmag;
  logic [LSUM_W+GAIN_W-1:0]         lprod;
  logic [LSUM_W-1:0]                lq;
  logic signed [LSUM_W:0]           lscaled;
  logic [BOUND_W-1:0]               bound;
  logic signed [LSUM_W:0]           bound_s;
  logic signed [LSUM_W:0]           lclamped;

  // Slope path: diff in fixed point, leaky average, truncate toward zero.
  assign raw_ext = RAW_EXT_W'(raw);
  assign raw_s   = raw_ext[SAMPLE_BITS-1:0];
  assign delta   = $signed({1'b0, raw_s}) - $signed({1'b0, last});
  assign diff    = $signed({delta, {FRAC_BITS{1'b0}}});
  assign err     = ERR_W'(diff) - ERR_W'(slope);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign err_prod = (ERR_W+GAIN_W)'(err_mag) * (ERR_W+GAIN_W)'(cfg.slope_gain);
  assign err_q   = err_prod[ERR_W+GAIN_W-1:GAIN_SHIFT];
  assign err_scaled = err[ERR_W-1] ? -$signed(SSUM_W'(err_q)) : $signed(SSUM_W'(err_q));
  assign slope_sum  = SSUM_W'(slope) + err_scaled;

  always_comb begin
    if (slope_sum > SLOPE_MAX) begin
      slope_clamped = SLOPE_MAX;
    end else if (slope_sum < -SLOPE_MAX) begin
      slope_clamped = -SLOPE_MAX;
    end else begin
      slope_clamped = slope_sum;
    end
  end
  assign slope_next = slope_clamped[SLOPE_W-1:0];

  // Level path: integrate slope, leak, clamp to the limit.
  assign lsum  = LSUM_W'(level) + LSUM_W'(slope);
  assign lmag  = lsum[LSUM_W-1] ? LSUM_W'(-lsum) : LSUM_W'(lsum);
  assign lprod = (LSUM_W+GAIN_W)'(lmag) * (LSUM_W+GAIN_W)'(cfg.decay_gain);
  assign lq    = lprod[LSUM_W+GAIN_W-1:GAIN_SHIFT];
  assign lscaled = lsum[LSUM_W-1] ? -$signed((LSUM_W+1)'(lq)) : $signed((LSUM_W+1)'(lq));
  assign bound   = {cfg.output_limit, {FRAC_BITS{1'b0}}};
  assign bound_s = $signed((LSUM_W+1)'(bound));

  always_comb begin
    if (lscaled > bound_s) begin
      lclamped = bound_s;
    end else if (lscaled < -bound_s) begin
      lclamped = -bound_s;
    end else begin
      lclamped = lscaled;
    end
  end
  assign level_next = lclamped[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last  <= '0;
      slope <= '0;
      level <= '0;
    end else begin
      if (ctl.sample_fire) begin
        if (raw_s != last) begin
          slope <= slope_next;
        end
        last <= raw_s;
      end
      if (ctl.level_fire) begin
        level <= level_next;
      end
    end
  end

`include "ppg_slope_smoothing_filter_assert.svh"

`PSSF_ASSERT_NEXT(a_slope_holds, !ctl.sample_fire, $stable(slope), "slope moved without a sample")
`PSSF_ASSERT_NEXT(a_level_bounded, ctl.level_fire, (level <= $past(bound_s)) && (level >= -$past(bound_s)), "level outside clamp bound")

endmodule

### design/pssf_merge.sv
//------------------------------------------------------------------------------
// pssf_merge
// Output register: packs both lane levels into one result transfer.
//------------------------------------------------------------------------------
module pssf_merge import pssf_pkg::*; #(
  parameter int LEVEL_W = LIMIT_W + FRAC_BITS_DEF + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      level_fire,
  input  logic signed [LEVEL_W-1:0] infrared_level,
  input  logic signed [LEVEL_W-1:0] red_level,
  input  logic                      result_stall,
  output logic                      result_valid,
  output result_t                   result_data,
  output logic                      out_free
);

  localparam int EXT_W = (LEVEL_W > LEVEL_OUT_W) ? LEVEL_W : LEVEL_OUT_W;

  logic signed [EXT_W-1:0] infrared_ext;
  logic signed [EXT_W-1:0] red_ext;

  assign infrared_ext = EXT_W'(infrared_level);
  assign red_ext      = EXT_W'(red_level);
  assign out_free     = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (level_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (level_fire) begin
      result_data.infrared_level <= infrared_ext[LEVEL_OUT_W-1:0];
      result_data.red_level      <= red_ext[LEVEL_OUT_W-1:0];
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-channel slope smoothing filter.
//------------------------------------------------------------------------------
// Ticks go in on the tick channel. Each accepted tick steps a local copy of
// the filter: slopes, last samples, levels and the gains and limit. The bench
// queues the levels it expects, and a monitor compares every result transfer
// with the oldest entry. Gains and limit change over the APB port only while
// the filter is drained. Every register write is read back. Both channels
// idle and stall at random, except for one full-rate stretch.
//------------------------------------------------------------------------------
module tb_top;
  import pssf_pkg::*;

  localparam int SLOPE_W = SAMPLE_BITS_DEF + 1 + FRAC_BITS_DEF;
  localparam longint SLOPE_MAX = (longint'(1) <<< (SAMPLE_BITS_DEF + FRAC_BITS_DEF)) - 1;
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 4'd12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int FULL_RATE_TICKS = 300;
  localparam int SWEEP_PHASES = 10;
  localparam int SWEEP_TICKS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  tick_valid = 1'b0;
  logic                  tick_stall;
  tick_t                 tick_data = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ppg_slope_smoothing_filter dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick_data    (tick_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Local copy of the filter state and its register settings.
  cfg_t                      level_cfg = '{SLOPE_GAIN_RST, DECAY_GAIN_RST, OUTPUT_LIMIT_RST};
  logic [RAW_W-1:0]          ir_last = '0;
  logic [RAW_W-1:0]          red_last = '0;
  logic signed [SLOPE_W-1:0] ir_slope = '0;
  logic signed [SLOPE_W-1:0] red_slope = '0;
  logic signed [LEVEL_OUT_W-1:0] ir_level = '0;
  logic signed [LEVEL_OUT_W-1:0] red_level = '0;

  // Levels expected on result transfers, oldest first.
  result_t pending_levels[$];
  result_t want;

  // Pulse-like waveform that the random stimulus follows.
  logic [RAW_W-1:0] ir_wave = 16'h4000;
  logic [RAW_W-1:0] red_wave = 16'h3000;

  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  int stall_left = 0;

  int errors = 0;
  int cycle_count = 0;
  int ticks_sent = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int settings_used = 1;

  task automatic report_error(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // x * gain / 256, truncated toward zero.
  function automatic longint apply_gain(longint x, logic [GAIN_W-1:0] gain);
    longint mag;
    longint g;
    g = longint'(gain);
    mag = (x < 0) ? -x : x;
    mag = (mag * g) >>> GAIN_SHIFT;
    return (x < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_mag(longint x, longint bound);
    if (x > bound) return bound;
    if (x < -bound) return -bound;
    return x;
  endfunction

  function automatic logic signed [SLOPE_W-1:0] next_slope(logic signed [SLOPE_W-1:0] slope,
                                                           logic [RAW_W-1:0] last,
                                                           logic [RAW_W-1:0] raw);
    longint cur;
    longint r;
    longint l;
    longint step;
    if (raw == last) return slope;
    cur = longint'(slope);
    r = longint'(raw);
    l = longint'(last);
    step = (r - l) <<< FRAC_BITS_DEF;
    return SLOPE_W'(clamp_mag(cur + apply_gain(step - cur, level_cfg.slope_gain), SLOPE_MAX));
  endfunction

  function automatic logic signed [LEVEL_OUT_W-1:0] next_level(
      logic signed [LEVEL_OUT_W-1:0] level, logic signed [SLOPE_W-1:0] slope, longint bound);
    longint a;
    longint b;
    a = longint'(level);
    b = longint'(slope);
    return LEVEL_OUT_W'(clamp_mag(apply_gain(a + b, level_cfg.decay_gain), bound));
  endfunction

  // Step the local filter by one accepted tick and queue the levels it yields.
  function automatic void advance_filter(tick_t t);
    longint bound;
    result_t lv;
    if (t.sample_valid) begin
      ir_slope = next_slope(ir_slope, ir_last, t.raw_infrared);
      red_slope = next_slope(red_slope, red_last, t.raw_red);
      ir_last = t.raw_infrared;
      red_last = t.raw_red;
    end
    bound = longint'(level_cfg.output_limit);
    bound = bound <<< FRAC_BITS_DEF;
    ir_level = next_level(ir_level, ir_slope, bound);
    red_level = next_level(red_level, red_slope, bound);
    lv.infrared_level = ir_level;
    lv.red_level = red_level;
    pending_levels.push_back(lv);
  endfunction

  function automatic tick_t tk(logic valid, logic [RAW_W-1:0] ir, logic [RAW_W-1:0] red);
    tick_t t;
    t.sample_valid = valid;
    t.raw_infrared = ir;
    t.raw_red = red;
    return t;
  endfunction

  // Mostly a wandering pulse with occasional held samples; the rest are empty
  // ticks, full-range jumps and rail values.
  function automatic tick_t make_tick();
    tick_t t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(99) >= 15) ir_wave = ir_wave + RAW_W'(int'($urandom_range(600)) - 300);
      if ($urandom_range(99) >= 15) red_wave = red_wave + RAW_W'(int'($urandom_range(600)) - 300);
      t = tk(1'b1, ir_wave, red_wave);
    end else if (pick < 82) begin
      t = tk(1'b0, RAW_W'($urandom()), RAW_W'($urandom()));
    end else if (pick < 95) begin
      t = tk(1'b1, RAW_W'($urandom()), RAW_W'($urandom()));
    end else begin
      t = tk(1'b1, $urandom_range(1) ? 16'hFFFF : 16'h0000,
             $urandom_range(1) ? 16'hFFFF : 16'h0000);
    end
    if (t.sample_valid) begin
      ir_wave = t.raw_infrared;
      red_wave = t.raw_red;
    end
    return t;
  endfunction

  // Offer one tick, hold it until the transfer, then step the local filter.
  task automatic send_tick(tick_t t);
    if (gaps_on && $urandom_range(99) < 6) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    advance_filter(t);
    ticks_sent++;
    if (t.sample_valid) samples_sent++;
  endtask

  // Drop valid and wait until every queued level has come back.
  task automatic settle_filter();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then one idle cycle so the next transfer
  // never reassigns psel in the same step.
  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(reg_idx_t idx);
    logic [APB_DATA_W-1:0] got;
    logic [APB_DATA_W-1:0] want_val;
    case (idx)
      REG_SLOPE_GAIN: want_val = APB_DATA_W'(level_cfg.slope_gain);
      REG_DECAY_GAIN: want_val = APB_DATA_W'(level_cfg.decay_gain);
      default:        want_val = APB_DATA_W'(level_cfg.output_limit);
    endcase
    apb_read({idx, 2'b00}, got);
    if (got !== want_val)
      report_error($sformatf("register %s reads %0d, expected %0d", idx.name(), got, want_val));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    apb_write({idx, 2'b00}, value);
    case (idx)
      REG_SLOPE_GAIN: level_cfg.slope_gain = value[GAIN_W-1:0];
      REG_DECAY_GAIN: level_cfg.decay_gain = value[GAIN_W-1:0];
      default:        level_cfg.output_limit = value[LIMIT_W-1:0];
    endcase
    check_reg(idx);
  endtask

  task automatic apply_setting(logic [GAIN_W-1:0] sg, logic [GAIN_W-1:0] dg,
                               logic [LIMIT_W-1:0] lim);
    write_reg(REG_SLOPE_GAIN, APB_DATA_W'(sg));
    write_reg(REG_DECAY_GAIN, APB_DATA_W'(dg));
    write_reg(REG_OUTPUT_LIMIT, APB_DATA_W'(lim));
    settings_used++;
  endtask

  // Random receiver stall in short bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(99) < 4) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(4);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Result monitor: every transfer pops the oldest expected level pair.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        report_error("result transfer with no tick outstanding");
      end else begin
        want = pending_levels.pop_front();
        if (result_data.infrared_level !== want.infrared_level)
          report_error($sformatf("result %0d infrared_level %0d, expected %0d", results_seen,
                                 result_data.infrared_level, want.infrared_level));
        if (result_data.red_level !== want.red_level)
          report_error($sformatf("result %0d red_level %0d, expected %0d", results_seen,
                                 result_data.red_level, want.red_level));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_levels.size());
      $display("ppg_slope_smoothing_filter regression: fail");
      $finish;
    end
  end

  // Each register must read back the value last set, the reset value before any write.
  task automatic test_reset_registers();
    check_reg(REG_SLOPE_GAIN);
    check_reg(REG_DECAY_GAIN);
    check_reg(REG_OUTPUT_LIMIT);
  endtask

  // Rail samples, held samples and empty ticks at the default gains.
  task automatic test_directed_ticks();
    send_tick(tk(1'b0, 16'hFFFF, 16'hFFFF));  // empty tick: raw ignored, levels stay zero
    send_tick(tk(1'b1, 16'h0000, 16'h0000));  // same as reset sample: slopes hold
    send_tick(tk(1'b1, 16'hFFFF, 16'hFFFF));  // full positive jump, levels hit the clamp
    send_tick(tk(1'b1, 16'hFFFF, 16'hFFFF));  // held sample
    send_tick(tk(1'b0, 16'h0000, 16'h0000));
    send_tick(tk(1'b0, 16'h1234, 16'hEDCB));
    send_tick(tk(1'b1, 16'h0000, 16'h0000));  // full negative jump
    send_tick(tk(1'b1, 16'h0000, 16'hFFFF));
    send_tick(tk(1'b1, 16'hFFFF, 16'h0000));
    send_tick(tk(1'b1, 16'h8000, 16'h7FFF));
    send_tick(tk(1'b1, 16'h8000, 16'h7FFF));
    send_tick(tk(1'b1, 16'h8000, 16'h1111));  // only red changes
    repeat (6) send_tick(tk(1'b0, 16'h5A5A, 16'hA5A5));  // leak with slopes held
    send_tick(tk(1'b1, 16'h0001, 16'h0001));
    send_tick(tk(1'b1, 16'h0000, 16'h0000));
    send_tick(tk(1'b1, 16'hAAAA, 16'h5555));
    send_tick(tk(1'b1, 16'h5555, 16'hAAAA));
  endtask

  // Back-to-back transfers with no gaps and no stalls, paused once mid-stream.
  task automatic test_full_rate_stream();
    settle_filter();
    apply_setting(SLOPE_GAIN_RST, DECAY_GAIN_RST, OUTPUT_LIMIT_RST);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    for (int n = 0; n < FULL_RATE_TICKS; n++) begin
      if (n == FULL_RATE_TICKS / 2) settle_filter();
      send_tick(make_tick());
    end
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // Random streams across extreme and random gain/limit settings.
  task automatic test_gain_limit_sweep();
    logic [GAIN_W-1:0]  sg;
    logic [GAIN_W-1:0]  dg;
    logic [LIMIT_W-1:0] lim;
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      settle_filter();
      case (p)
        0: begin sg = 8'd0;   dg = 8'd0;   lim = 15'd1;     end
        1: begin sg = 8'd255; dg = 8'd255; lim = 15'd32767; end
        2: begin sg = 8'd255; dg = 8'd0;   lim = 15'd32767; end
        3: begin sg = 8'd128; dg = 8'd255; lim = 15'd0;     end  // zero limit pins levels
        4: begin sg = 8'd1;   dg = 8'd254; lim = 15'd32767; end
        default: begin
          sg = GAIN_W'($urandom_range(255));
          dg = GAIN_W'($urandom_range(255));
          lim = $urandom_range(1) ? LIMIT_W'($urandom_range(1000, 1))
                                  : LIMIT_W'($urandom_range(32767, 1));
        end
      endcase
      apply_setting(sg, dg, lim);
      if (p == 5) begin
        // Unmapped address: the write must not disturb any register.
        apb_write(UNMAPPED_ADDR, $urandom());
        test_reset_registers();
      end
      for (int n = 0; n < SWEEP_TICKS; n++) begin
        if (n == SWEEP_TICKS / 2 && p % 3 == 1) settle_filter();
        send_tick(make_tick());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_registers();
    test_directed_ticks();
    test_full_rate_stream();
    test_gain_limit_sweep();
    settle_filter();
    $display("covered %0d ticks (%0d with samples) under %0d gain/limit settings",
             ticks_sent, samples_sent, settings_used);
    $display("checked %0d result transfers, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("ppg_slope_smoothing_filter regression: pass");
    end else begin
      $display("ppg_slope_smoothing_filter regression: fail");
    end
    $finish;
  end

endmodule

### ppg_slope_smoothing_filter.f
+incdir+design
design/pssf_pkg.sv
design/pssf_lane.sv
design/pssf_merge.sv
design/ppg_slope_smoothing_filter.sv
tb/tb_top.sv
